FILE: src/mbg_pkg.sv
// Shared package for the maze backtracker generator: sizes, codes, types and
// small helper functions used by the top level and the neighbor unit.
// Depends on nothing.
package mbg_pkg;

    localparam int COORD_W     = 6;
    localparam int CELL_W      = 2 * COORD_W;
    localparam int MAX_GRID    = 63;
    localparam int GRID_LIM    = (MAX_GRID - 1) | 1;
    localparam int MIN_GRID    = 5;
    localparam int STACK_DEPTH = 1024;
    localparam int SPTR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = SPTR_W + 1;
    localparam int VIS_AW      = 2 * COORD_W;
    localparam int VIS_DEPTH   = 1 << VIS_AW;
    localparam int NUM_DIRS    = 4;
    localparam int DIR_CNT_W   = 3;
    localparam int CAND_CNT_W  = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int RAND_W      = 8;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_cell;

    typedef struct packed {
        logic  ok;
        t_cell pos;
    } t_nbr;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE  = 2'd0,
        CFG_EXIT_AXIS  = 2'd1,
        CFG_EXIT_INDEX = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FUNC_STEP    = 1'b0,
        FUNC_RESTART = 1'b1
    } t_func;

    typedef enum logic {
        AXIS_BOTTOM = 1'b0,
        AXIS_RIGHT  = 1'b1
    } t_axis;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_SCAN,
        S_DECIDE,
        S_POPRD,
        S_OUT
    } t_state;

    // Effective grid side: forced odd, then clamped to the legal range.
    function automatic logic [COORD_W-1:0] size_now(input logic [COORD_W-1:0] gs);
        logic [COORD_W-1:0] n;
        n = gs | COORD_W'(1);
        if (n < COORD_W'(MIN_GRID)) n = COORD_W'(MIN_GRID);
        if (n > COORD_W'(GRID_LIM)) n = COORD_W'(GRID_LIM);
        return n;
    endfunction

    // Exit cell on the bottom row or right column.
    function automatic t_cell exit_cell(input logic [COORD_W-1:0] n,
                                        input logic               axis,
                                        input logic [COORD_W-1:0] idx);
        logic [COORD_W-1:0] e;
        t_cell              c;
        e = idx | COORD_W'(1);
        if (e > n - COORD_W'(2)) e = n - COORD_W'(2);
        if (axis == AXIS_BOTTOM) begin
            c.row = n - COORD_W'(1);
            c.col = e;
        end else begin
            c.row = e;
            c.col = n - COORD_W'(1);
        end
        return c;
    endfunction

    // rand mod count for a count of one to four. Division by three uses the
    // reciprocal 171/512, which is exact for all 8-bit values.
    function automatic logic [1:0] pick_index(input logic [RAND_W-1:0]     v,
                                              input logic [CAND_CNT_W-1:0] cnt);
        logic [2*RAND_W-1:0] prod;
        logic [RAND_W-2:0]   q;
        logic [RAND_W-1:0]   rem;
        logic [1:0]          res;
        prod = (2*RAND_W)'(v) * (2*RAND_W)'(171);
        q    = prod[2*RAND_W-1:9];
        rem  = v - ({q, 1'b0} + {1'b0, q});
        case (cnt)
            CAND_CNT_W'(2): res = {1'b0, v[0]};
            CAND_CNT_W'(3): res = rem[1:0];
            CAND_CNT_W'(4): res = v[1:0];
            default:        res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

FILE: src/mbg_ram.sv
// Generic single-write, single-read memory with registered read data.
// Used for the visited map and the path stack. Depends on nothing.
module mbg_ram #(
    parameter int   WIDTH = 1,
    parameter int   DEPTH = 16,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mbg_nbr.sv
// Neighbor unit: forms the neighbor of a cell in one direction and checks it
// against the grid bounds and the room (odd, odd) lattice. Depends on mbg_pkg.
module mbg_nbr (
    input  mbg_pkg::t_cell                i_cell,
    input  mbg_pkg::t_dir                 i_dir,
    input  logic                          i_near,
    input  logic [mbg_pkg::COORD_W-1:0]   i_size,
    output mbg_pkg::t_nbr                 o_nbr
);

    localparam int EW = mbg_pkg::COORD_W + 2;

    logic [EW-1:0] off;
    logic [EW-1:0] r_ext;
    logic [EW-1:0] c_ext;
    logic [EW-1:0] n_ext;
    logic [EW-1:0] nr;
    logic [EW-1:0] nc;

    always_comb begin
        off   = i_near ? EW'(1) : EW'(2);
        r_ext = EW'(i_cell.row);
        c_ext = EW'(i_cell.col);
        n_ext = EW'(i_size);
        nr    = r_ext;
        nc    = c_ext;
        case (i_dir)
            mbg_pkg::DIR_UP:    nr = r_ext - off;
            mbg_pkg::DIR_DOWN:  nr = r_ext + off;
            mbg_pkg::DIR_LEFT:  nc = c_ext - off;
            mbg_pkg::DIR_RIGHT: nc = c_ext + off;
            default:            nr = r_ext;
        endcase
        // A step below zero wraps and sets the top bit.
        o_nbr.ok = !nr[EW-1] && !nc[EW-1] && (nr < n_ext) && (nc < n_ext)
                   && nr[0] && nc[0];
        o_nbr.pos.row = nr[mbg_pkg::COORD_W-1:0];
        o_nbr.pos.col = nc[mbg_pkg::COORD_W-1:0];
    end

endmodule

FILE: src/maze_backtracker_generator_top.sv
// Top level of the maze backtracker generator: sequencer, configuration
// registers and result register. Depends on mbg_pkg, mbg_ram and mbg_nbr.
//
// Randomized depth-first maze carver. Rooms sit at odd (row, column) places
// of an odd-sized square grid; the exit lies on the bottom row or the right
// column. A restart transfer clears the visited map and seeds the path stack
// with the exit; each step transfer carves at most one move and returns the
// removed wall cell, if any, the new current cell and a done flag. The block
// handles one item at a time and is not ready while it works. A restart
// clears the visited map one entry per cycle through its single write port,
// then seeds the stack. In a step one neighbor is tested per cycle by the
// shared neighbor unit against the visited memory, whose read data is
// registered, then a decide state picks a candidate. Every exhausted cell
// that must be popped on the way adds a decide, a stack read and another
// neighbor scan. A step on an empty stack goes straight to the result. The
// result stays in its register until it is taken; the user must write
// configuration only while the block is idle, and the block has no guard.
module maze_backtracker_generator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [mbg_pkg::RAND_W-1:0]      i_rand_value,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_carved_valid,
    output logic [mbg_pkg::COORD_W-1:0]     o_carved_row,
    output logic [mbg_pkg::COORD_W-1:0]     o_carved_col,
    output logic [mbg_pkg::COORD_W-1:0]     o_cell_row,
    output logic [mbg_pkg::COORD_W-1:0]     o_cell_col,
    output logic                            o_done_res
);

    localparam int CW = mbg_pkg::COORD_W;

    mbg_pkg::t_state r_state;
    mbg_pkg::t_state n_state;

    // Configuration registers.
    logic [CW-1:0] r_grid_size;
    logic          r_exit_axis;
    logic [CW-1:0] r_exit_index;

    // Generation state.
    logic [mbg_pkg::CNT_W-1:0] r_count;
    mbg_pkg::t_cell            r_cur;
    logic                      r_first;

    // Per-item working registers.
    logic [mbg_pkg::RAND_W-1:0]     r_rand;
    logic [mbg_pkg::VIS_AW-1:0]     r_clr_addr;
    logic [mbg_pkg::DIR_CNT_W-1:0]  r_dir;
    logic                           r_chk_ok;
    mbg_pkg::t_cell                 r_chk_cell;
    logic [mbg_pkg::CAND_CNT_W-1:0] r_cnt;
    mbg_pkg::t_cell                 r_cand [mbg_pkg::NUM_DIRS];

    // Result registers.
    logic          r_carved_valid;
    logic [CW-1:0] r_carved_row;
    logic [CW-1:0] r_carved_col;

    logic                      in_xfer;
    logic [CW-1:0]             size_n;
    mbg_pkg::t_nbr             nbr;
    logic                      scan_last;
    logic [1:0]                pick;
    mbg_pkg::t_cell            sel;
    logic [CW:0]               sum_row;
    logic [CW:0]               sum_col;
    logic                      stack_full;
    logic [mbg_pkg::CNT_W-1:0] pop_idx;

    // Memory controls.
    logic                          vis_we;
    logic [mbg_pkg::VIS_AW-1:0]    vis_waddr;
    logic                          vis_wdata;
    logic                          vis_re;
    logic                          vis_rdata;
    logic                          stk_we;
    logic [mbg_pkg::SPTR_W-1:0]    stk_waddr;
    logic [mbg_pkg::CELL_W-1:0]    stk_wdata;
    logic                          stk_re;
    logic [mbg_pkg::SPTR_W-1:0]    stk_raddr;
    logic [mbg_pkg::CELL_W-1:0]    stk_rdata;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign size_n    = mbg_pkg::size_now(r_grid_size);
    assign scan_last = (r_dir == mbg_pkg::DIR_CNT_W'(mbg_pkg::NUM_DIRS));

    // Candidate selection and the wall cell halfway to it.
    assign pick       = mbg_pkg::pick_index(r_rand, r_cnt);
    assign sel        = r_cand[pick];
    assign sum_row    = {1'b0, r_cur.row} + {1'b0, sel.row};
    assign sum_col    = {1'b0, r_cur.col} + {1'b0, sel.col};
    assign stack_full = (r_count == mbg_pkg::CNT_W'(mbg_pkg::STACK_DEPTH));
    assign pop_idx    = r_count - mbg_pkg::CNT_W'(2);

    // The shared neighbor unit walks the four directions of the current cell.
    mbg_nbr u_nbr (
        .i_cell (r_cur),
        .i_dir  (mbg_pkg::t_dir'(r_dir[1:0])),
        .i_near (r_first),
        .i_size (size_n),
        .o_nbr  (nbr)
    );

    mbg_ram #(
        .WIDTH (1),
        .DEPTH (mbg_pkg::VIS_DEPTH)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_re    (vis_re),
        .i_raddr (nbr.pos),
        .o_rdata (vis_rdata)
    );

    mbg_ram #(
        .WIDTH (mbg_pkg::CELL_W),
        .DEPTH (mbg_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbg_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_func == mbg_pkg::FUNC_RESTART) begin
                        n_state = mbg_pkg::S_CLEAR;
                    end else if (r_count != '0) begin
                        n_state = mbg_pkg::S_SCAN;
                    end else begin
                        n_state = mbg_pkg::S_OUT;
                    end
                end
            end
            mbg_pkg::S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = mbg_pkg::S_SEED;
                end
            end
            mbg_pkg::S_SEED: n_state = mbg_pkg::S_OUT;
            mbg_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = mbg_pkg::S_DECIDE;
                end
            end
            mbg_pkg::S_DECIDE: begin
                if (r_cnt == '0 && r_count > mbg_pkg::CNT_W'(1)) begin
                    n_state = mbg_pkg::S_POPRD;
                end else begin
                    n_state = mbg_pkg::S_OUT;
                end
            end
            mbg_pkg::S_POPRD: n_state = mbg_pkg::S_SCAN;
            mbg_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = mbg_pkg::S_IDLE;
                end
            end
            default: n_state = mbg_pkg::S_IDLE;
        endcase
    end

    // Handshake and memory control outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        vis_we      = 1'b0;
        vis_waddr   = r_clr_addr;
        vis_wdata   = 1'b0;
        vis_re      = 1'b0;
        stk_we      = 1'b0;
        stk_waddr   = r_count[mbg_pkg::SPTR_W-1:0];
        stk_wdata   = sel;
        stk_re      = 1'b0;
        stk_raddr   = pop_idx[mbg_pkg::SPTR_W-1:0];
        case (r_state)
            mbg_pkg::S_IDLE: o_in_ready = 1'b1;
            mbg_pkg::S_CLEAR: vis_we = 1'b1;
            mbg_pkg::S_SEED: begin
                // The exit is visited and becomes the bottom of the stack.
                vis_we    = 1'b1;
                vis_waddr = r_cur;
                vis_wdata = 1'b1;
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = r_cur;
            end
            mbg_pkg::S_SCAN: vis_re = !scan_last;
            mbg_pkg::S_DECIDE: begin
                if (r_cnt != '0) begin
                    vis_we    = 1'b1;
                    vis_waddr = sel;
                    vis_wdata = 1'b1;
                    stk_we    = 1'b1;
                    // A full stack overwrites its top entry.
                    stk_waddr = stack_full ? mbg_pkg::SPTR_W'(mbg_pkg::STACK_DEPTH - 1)
                                           : r_count[mbg_pkg::SPTR_W-1:0];
                end else begin
                    stk_re = (r_count > mbg_pkg::CNT_W'(1));
                end
            end
            mbg_pkg::S_OUT: o_out_valid = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= mbg_pkg::S_IDLE;
            r_grid_size    <= CW'(63);
            r_exit_axis    <= mbg_pkg::AXIS_BOTTOM;
            r_exit_index   <= CW'(1);
            r_count        <= '0;
            r_cur          <= '0;
            r_first        <= 1'b1;
            r_carved_valid <= 1'b0;
            r_carved_row   <= '0;
            r_carved_col   <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    mbg_pkg::CFG_GRID_SIZE:  r_grid_size  <= i_cfg_data;
                    mbg_pkg::CFG_EXIT_AXIS:  r_exit_axis  <= i_cfg_data[0];
                    mbg_pkg::CFG_EXIT_INDEX: r_exit_index <= i_cfg_data;
                    default:                 r_grid_size  <= r_grid_size;
                endcase
            end

            case (r_state)
                mbg_pkg::S_IDLE: begin
                    if (in_xfer) begin
                        r_rand <= i_rand_value;
                        if (i_func == mbg_pkg::FUNC_RESTART) begin
                            r_cur      <= mbg_pkg::exit_cell(size_n, r_exit_axis,
                                                             r_exit_index);
                            r_clr_addr <= '0;
                        end else begin
                            r_dir          <= '0;
                            r_chk_ok       <= 1'b0;
                            r_cnt          <= '0;
                            r_carved_valid <= 1'b0;
                            r_carved_row   <= '0;
                            r_carved_col   <= '0;
                        end
                    end
                end
                mbg_pkg::S_CLEAR: r_clr_addr <= r_clr_addr + 1'b1;
                mbg_pkg::S_SEED: begin
                    r_count        <= mbg_pkg::CNT_W'(1);
                    r_first        <= 1'b1;
                    r_carved_valid <= 1'b0;
                    r_carved_row   <= '0;
                    r_carved_col   <= '0;
                end
                mbg_pkg::S_SCAN: begin
                    // Issue one neighbor per cycle; its visited bit returns
                    // in the next cycle and is judged there.
                    if (!scan_last) begin
                        r_chk_ok   <= nbr.ok;
                        r_chk_cell <= nbr.pos;
                        r_dir      <= r_dir + 1'b1;
                    end else begin
                        r_chk_ok <= 1'b0;
                    end
                    if (r_chk_ok && !vis_rdata) begin
                        r_cand[r_cnt[1:0]] <= r_chk_cell;
                        r_cnt              <= r_cnt + 1'b1;
                    end
                end
                mbg_pkg::S_DECIDE: begin
                    if (r_cnt == '0) begin
                        // Exhausted cell: pop it. The current cell keeps it
                        // when the stack runs empty.
                        r_count <= r_count - 1'b1;
                        r_first <= 1'b0;
                    end else begin
                        r_carved_valid <= !r_first;
                        r_carved_row   <= r_first ? '0 : sum_row[CW:1];
                        r_carved_col   <= r_first ? '0 : sum_col[CW:1];
                        r_cur          <= sel;
                        r_first        <= 1'b0;
                        if (!stack_full) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                mbg_pkg::S_POPRD: begin
                    r_cur    <= stk_rdata;
                    r_dir    <= '0;
                    r_chk_ok <= 1'b0;
                    r_cnt    <= '0;
                end
                default: r_first <= r_first;
            endcase
        end
    end

    assign o_carved_valid = r_carved_valid;
    assign o_carved_row   = r_carved_row;
    assign o_carved_col   = r_carved_col;
    assign o_cell_row     = r_cur.row;
    assign o_cell_col     = r_cur.col;
    assign o_done_res     = (r_count == '0);

endmodule

FILE: src/mbg_checker.sv
// Port-level checker for the maze backtracker generator, bound to the top.
// Depends on mbg_pkg and maze_backtracker_generator_top.
module mbg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_carved_valid,
    input logic [mbg_pkg::COORD_W-1:0]    o_carved_row,
    input logic [mbg_pkg::COORD_W-1:0]    o_carved_col,
    input logic [mbg_pkg::COORD_W-1:0]    o_cell_row,
    input logic                           o_done_res
);

    // The block never offers to take an item while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // In the cycle after an input transfer the block is busy.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // A stalled result holds its cell row and done flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_cell_row) && $stable(o_done_res)))
        else $error("stalled result changed");

    // A finished maze carves nothing.
    a_done_no_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_carved_valid)
        else $error("carve reported with done");

    // Without a carve the wall coordinates read as zero.
    a_zero_wall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_carved_valid) |->
            (o_carved_row == '0 && o_carved_col == '0))
        else $error("wall coordinates set without a carve");

endmodule

bind maze_backtracker_generator_top mbg_checker u_mbg_checker (.*);

FILE: verif/maze_carve_checker.sv
// Result checker for the maze backtracker generator: watches the configuration
// port and both handshake channels, predicts each carve step and compares.
// Depends on mbg_pkg for field widths, codes and the cell type.
module maze_carve_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_func,
    input  logic [mbg_pkg::RAND_W-1:0]      i_rand_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_carved_valid,
    input  logic [mbg_pkg::COORD_W-1:0]     i_carved_row,
    input  logic [mbg_pkg::COORD_W-1:0]     i_carved_col,
    input  logic [mbg_pkg::COORD_W-1:0]     i_cell_row,
    input  logic [mbg_pkg::COORD_W-1:0]     i_cell_col,
    input  logic                            i_done_res,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mbg_pkg::*;

    typedef struct packed {
        logic               carved_valid;
        logic [COORD_W-1:0] carved_row;
        logic [COORD_W-1:0] carved_col;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               done;
    } t_move;

    logic [COORD_W-1:0] grid_size_q;
    logic               exit_axis_q;
    logic [COORD_W-1:0] exit_index_q;
    logic               visited [0:(1<<COORD_W)-1][0:(1<<COORD_W)-1];
    t_cell              path_stack [0:STACK_DEPTH-1];
    int                 stack_cnt;
    t_cell              cur_cell;
    logic               first_mv;
    t_move              expected_moves [$];
    t_move              got;
    t_move              want;
    int                 result_idx;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic int side_length();
        int n;
        n = int'(grid_size_q) | 1;
        if (n < MIN_GRID) n = MIN_GRID;
        if (n > GRID_LIM) n = GRID_LIM;
        return n;
    endfunction

    // Unvisited rooms around a cell in the order up, down, left, right.
    function automatic int open_rooms(input t_cell room, input logic near, input int n,
                                      output int rr[4], output int cc[4]);
        int dr[4];
        int dc[4];
        int r, c, off, k, nr, nc;
        dr = '{-1, 1, 0, 0};
        dc = '{0, 0, -1, 1};
        r = int'(room.row);
        c = int'(room.col);
        off = near ? 1 : 2;
        k = 0;
        rr = '{0, 0, 0, 0};
        cc = '{0, 0, 0, 0};
        for (int d = 0; d < NUM_DIRS; d++) begin
            nr = r + dr[d] * off;
            nc = c + dc[d] * off;
            if (nr < 0 || nr >= n || nc < 0 || nc >= n) continue;
            if ((nr % 2) == 0 || (nc % 2) == 0) continue;
            if (visited[nr][nc]) continue;
            rr[k] = nr;
            cc[k] = nc;
            k++;
        end
        return k;
    endfunction

    // Applies one input item to the predicted state and returns its result.
    function automatic void carve_step(input logic f, input logic [RAND_W-1:0] rnd,
                                       output t_move res);
        int n, e, er, ec, cnt, pick;
        int rr[4];
        int cc[4];
        n = side_length();
        res = '0;
        cnt = 0;
        if (f == FUNC_RESTART) begin
            e = int'(exit_index_q) | 1;
            if (e > n - 2) e = n - 2;
            if (exit_axis_q == AXIS_BOTTOM) begin
                er = n - 1;
                ec = e;
            end else begin
                er = e;
                ec = n - 1;
            end
            foreach (visited[i, j]) visited[i][j] = 1'b0;
            visited[er][ec] = 1'b1;
            cur_cell.row = COORD_W'(er);
            cur_cell.col = COORD_W'(ec);
            path_stack[0] = cur_cell;
            stack_cnt = 1;
            first_mv = 1'b1;
        end else if (stack_cnt > 0) begin
            while (stack_cnt > 0) begin
                cur_cell = path_stack[stack_cnt-1];
                cnt = open_rooms(cur_cell, first_mv, n, rr, cc);
                if (cnt > 0) break;
                stack_cnt--;
                first_mv = 1'b0;
            end
            if (stack_cnt > 0) begin
                pick = int'(rnd) % cnt;
                if (!first_mv) begin
                    res.carved_valid = 1'b1;
                    res.carved_row = COORD_W'((int'(cur_cell.row) + rr[pick]) / 2);
                    res.carved_col = COORD_W'((int'(cur_cell.col) + cc[pick]) / 2);
                end
                first_mv = 1'b0;
                visited[rr[pick]][cc[pick]] = 1'b1;
                cur_cell.row = COORD_W'(rr[pick]);
                cur_cell.col = COORD_W'(cc[pick]);
                // A full stack overwrites its top entry.
                if (stack_cnt < STACK_DEPTH) begin
                    path_stack[stack_cnt] = cur_cell;
                    stack_cnt++;
                end else begin
                    path_stack[STACK_DEPTH-1] = cur_cell;
                end
            end
        end
        res.cell_row = cur_cell.row;
        res.cell_col = cur_cell.col;
        res.done = (stack_cnt == 0);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_size_q = COORD_W'(MAX_GRID);
            exit_axis_q = AXIS_BOTTOM;
            exit_index_q = COORD_W'(1);
            foreach (visited[i, j]) visited[i][j] = 1'b0;
            stack_cnt = 0;
            cur_cell = '0;
            first_mv = 1'b1;
            result_idx = 0;
            expected_moves.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_SIZE:  grid_size_q = i_cfg_data;
                    CFG_EXIT_AXIS:  exit_axis_q = i_cfg_data[0];
                    CFG_EXIT_INDEX: exit_index_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_carved_valid, i_carved_row, i_carved_col,
                        i_cell_row, i_cell_col, i_done_res};
                if (expected_moves.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("result %0d arrived with nothing expected", result_idx);
                end else begin
                    want = expected_moves.pop_front();
                    if (got.carved_valid !== want.carved_valid ||
                        got.carved_row !== want.carved_row ||
                        got.carved_col !== want.carved_col ||
                        got.cell_row !== want.cell_row ||
                        got.cell_col !== want.cell_col ||
                        got.done !== want.done) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("result %0d expected wall=%0b (%0d,%0d) cell=(%0d,%0d) done=%0b",
                                     result_idx, want.carved_valid, want.carved_row,
                                     want.carved_col, want.cell_row, want.cell_col, want.done);
                            $display("result %0d actual   wall=%0b (%0d,%0d) cell=(%0d,%0d) done=%0b",
                                     result_idx, got.carved_valid, got.carved_row,
                                     got.carved_col, got.cell_row, got.cell_col, got.done);
                        end
                    end
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                carve_step(i_func, i_rand_value, want);
                expected_moves.insert(expected_moves.size(), want);
            end
            o_pending <= expected_moves.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// Top of the maze backtracker generator testbench: clock, reset, stimulus,
// output backpressure, watchdog and verdict. Depends on mbg_pkg, the block
// and maze_carve_checker, which does all prediction and comparison.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mbg_pkg::*;

    localparam int STALL_LIMIT  = 40000;   // cycles without any transfer
    localparam int HOLD_AT      = 150;     // results taken before the long hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 600;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  item_func = 1'b0;
    logic [RAND_W-1:0]     item_rand = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  carved_valid;
    logic [COORD_W-1:0]    carved_row;
    logic [COORD_W-1:0]    carved_col;
    logic [COORD_W-1:0]    cell_row;
    logic [COORD_W-1:0]    cell_col;
    logic                  done_res;
    int                    fail_count;
    int                    pending;

    // Random idling on both channels is switched off for one long stretch.
    bit                    gaps_on = 1'b1;
    bit                    long_hold_done = 1'b0;
    int                    results_taken = 0;
    int                    stall_cycles = 0;
    int                    random_items = 0;
    int                    phase_steps;
    int                    side;
    logic [RAND_W-1:0]     extreme_vals [6];

    maze_backtracker_generator_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (item_func),
        .i_rand_value   (item_rand),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_carved_valid (carved_valid),
        .o_carved_row   (carved_row),
        .o_carved_col   (carved_col),
        .o_cell_row     (cell_row),
        .o_cell_col     (cell_col),
        .o_done_res     (done_res)
    );

    maze_carve_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_func         (item_func),
        .i_rand_value   (item_rand),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_carved_valid (carved_valid),
        .i_carved_row   (carved_row),
        .i_carved_col   (carved_col),
        .i_cell_row     (cell_row),
        .i_cell_col     (cell_col),
        .i_done_res     (done_res),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Offers one item on the input channel and returns at the edge where the
    // transfer takes place. Valid is left high so that back-to-back items do not
    // drop it; a gap or a drain lowers it in the step of the previous transfer.
    task automatic send_item(input t_func f, input logic [RAND_W-1:0] value);
        while (gaps_on && $urandom_range(0, 99) < 12) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        item_func <= f;
        item_rand <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops offering and waits until every expected result has been taken.
    // The pending count is registered and lags behind a transfer, hence the first wait.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges; only called when idle.
    task automatic write_config(input logic [COORD_W-1:0] grid, input t_axis axis,
                                input logic [COORD_W-1:0] exit_pos);
        cfg_we <= 1'b1;
        cfg_index <= CFG_GRID_SIZE;
        cfg_data <= grid;
        @(posedge clk);
        cfg_index <= CFG_EXIT_AXIS;
        cfg_data <= CFG_DATA_W'(axis);
        @(posedge clk);
        cfg_index <= CFG_EXIT_INDEX;
        cfg_data <= exit_pos;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Directed run: restart from the exit and then a few steps with extreme
    // random values, enough on the smallest grid to walk past completion.
    task automatic directed_run(input int steps);
        send_item(FUNC_RESTART, 8'h00);
        for (int k = 0; k < steps; k++)
            send_item(FUNC_STEP, extreme_vals[k % 6]);
    endtask

    // Result side: random backpressure, plus one long hold-off once enough
    // results have gone by and the sender is offering, so the block stalls
    // its input for the whole stretch.
    initial begin
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) results_taken++;
            if (!long_hold_done && results_taken >= HOLD_AT && in_valid) begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= !(gaps_on && $urandom_range(0, 99) < 12);
        end
    end

    // Watchdog: any cycle with a transfer on either channel restarts the count.
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("maze_backtracker_generator_top: mismatch");
        $finish;
    end

    initial begin
        extreme_vals = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h7F};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A step before any restart must leave everything alone and report done.
        send_item(FUNC_STEP, 8'hFF);
        drain_results();

        // Smallest grid, carved to completion and stepped once past it.
        write_config(6'd5, AXIS_BOTTOM, 6'd1);
        directed_run(6);
        drain_results();

        // Grid size below range and exit index above range on the right edge.
        write_config(6'd0, AXIS_RIGHT, 6'd63);
        directed_run(5);
        drain_results();

        // Even grid size that rounds up to the largest grid, exit at the far end.
        write_config(6'd62, AXIS_BOTTOM, 6'd61);
        directed_run(4);
        drain_results();

        // Largest grid with an even exit index that is forced odd.
        write_config(6'd63, AXIS_RIGHT, 6'd0);
        directed_run(3);

        // Random phases. Each one sets the registers while idle, usually
        // restarts, and then carves about enough steps to finish the maze. A
        // quarter of the phases skip the restart so that the settings change
        // in the middle of a generation. A few items are noise: random
        // function codes that can restart a maze halfway through.
        while (random_items < RANDOM_ITEMS) begin
            drain_results();
            gaps_on = !(random_items >= 250 && random_items < 400);
            if ($urandom_range(0, 9) == 0)
                side = $urandom_range(0, 63);
            else
                side = 5 + 2 * $urandom_range(0, 5);
            write_config(COORD_W'(side), t_axis'($urandom_range(0, 1)),
                         COORD_W'($urandom_range(0, 63)));
            side = side | 1;
            if (side < MIN_GRID) side = MIN_GRID;
            if (side > GRID_LIM) side = GRID_LIM;
            phase_steps = ((side - 1) / 2) * ((side - 1) / 2) + $urandom_range(0, 6);
            if (phase_steps > 150) phase_steps = 40 + $urandom_range(0, 110);
            if ($urandom_range(0, 3) != 0) begin
                send_item(FUNC_RESTART, RAND_W'($urandom_range(0, 255)));
                random_items++;
            end
            for (int k = 0; k < phase_steps; k++) begin
                if ($urandom_range(0, 99) < 4)
                    send_item(t_func'($urandom_range(0, 1)),
                              RAND_W'($urandom_range(0, 255)));
                else
                    send_item(FUNC_STEP, RAND_W'($urandom_range(0, 255)));
            end
            random_items += phase_steps;
        end

        drain_results();
        // A few more cycles to catch any stray result after the last one.
        repeat (24) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("maze_backtracker_generator_top: match");
        else
            $display("maze_backtracker_generator_top: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
src/mbg_pkg.sv
src/mbg_ram.sv
src/mbg_nbr.sv
src/maze_backtracker_generator_top.sv
src/mbg_checker.sv
verif/maze_carve_checker.sv
verif/tb_top.sv
